// ===== hw/rtl/mdug_pkg.sv =====
// Package: payload types, register indexes, state codes and mu-law expansion.
package mdug_pkg;

  localparam int unsigned DivBits = 16;

  localparam logic [5:0] RATIO_MIN = 6'd1;
  localparam logic [5:0] RATIO_MAX = 6'd32;
  localparam logic [5:0] RATIO_RESET = 6'd6;
  localparam logic [15:0] MAX_GAP_RESET = 16'd24000;
  localparam logic [15:0] MULAW_BIAS = 16'h0084;

  // configuration register indexes
  localparam logic CFG_UPSAMPLE_RATIO = 1'b0;
  localparam logic CFG_MAX_GAP = 1'b1;

  typedef struct packed {
    logic [7:0] code;
    logic first_of_packet;
    logic [31:0] packet_timestamp;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic is_silence;
    logic [20:0] silence_count;
    logic last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_PREP,
    S_DIV,
    S_EMIT
  } state_t;

  // G.711 mu-law expansion, result in -32124..32124
  function automatic logic signed [15:0] mulaw_expand(input logic [7:0] code);
    logic [7:0] inv;
    logic [15:0] mag;
    begin
      inv = ~code;
      mag = {9'd0, inv[3:0], 3'b000} + MULAW_BIAS;
      mag = mag << inv[6:4];
      if (inv[7]) begin
        mulaw_expand = $signed(MULAW_BIAS - mag);
      end else begin
        mulaw_expand = $signed(mag - MULAW_BIAS);
      end
    end
  endfunction

endpackage

// ===== hw/rtl/mulaw_decode_upsample_gapfill_core.sv =====
// Top level: mu-law decoder with linear-interpolation upsampler and gap filler.
// A new byte is taken only after every result of the previous one is sent:
//   R ramp points (R = effective upsample ratio), preceded by one silence run
//   when a gap is filled; the ramp step comes from a bit-serial divider.
// Output stalls hold the sequence. rst (synchronous) clears timestamp
//   state and the previous sample and loads ratio 6 and max gap 24000.
module mulaw_decode_upsample_gapfill_core
  import mdug_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [5:0]  upsample_ratio;
  logic [15:0] max_gap;
  logic [5:0]  eff_ratio;

  // stream state
  logic        timestamp_seen;
  logic [31:0] expected_timestamp;
  logic signed [15:0] previous_sample;

  // per-item work registers
  state_t state, state_next;
  logic signed [15:0] new_sample;   // expanded byte
  logic [15:0] gap_lo;              // accepted gap, fits max_gap
  logic        diff_neg;            // new_sample below previous_sample
  logic [15:0] div_q;               // dividend in, quotient out (bit-serial)
  logic [5:0]  div_r;               // running remainder
  logic [3:0]  div_cnt;
  logic [15:0] acc_q;               // |d|*k / R, kept incrementally
  logic [5:0]  acc_r;               // |d|*k mod R
  logic [5:0]  k;

  logic        accept;
  logic        out_free;
  logic [31:0] gap;
  logic        gap_ok;

  // shared step logic
  logic [6:0]  div_part;
  logic        div_ge;
  logic signed [16:0] diff;
  logic [16:0] diff_mag;
  logic [6:0]  r_sum;
  logic        r_wrap;
  logic [5:0]  r_new;
  logic [15:0] q_new;
  logic signed [16:0] interp;
  logic [21:0] sil_prod;

  // ratio zero acts as one, above range saturates
  always_comb begin
    if (upsample_ratio == 6'd0) begin
      eff_ratio = RATIO_MIN;
    end else if (upsample_ratio > RATIO_MAX) begin
      eff_ratio = RATIO_MAX;
    end else begin
      eff_ratio = upsample_ratio;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // gap is signed modulo 2^32; only positive gaps up to max_gap are filled
  assign gap    = in_data.packet_timestamp - expected_timestamp;
  assign gap_ok = in_data.first_of_packet && timestamp_seen && (gap != 32'd0) &&
                  !gap[31] && (gap <= {16'd0, max_gap});

  // restoring divider step: |d| / R, one quotient bit per cycle
  assign div_part = {div_r, div_q[DivBits-1]};
  assign div_ge   = (div_part >= {1'b0, eff_ratio});

  // difference for the ramp
  assign diff     = {new_sample[15], new_sample} - {previous_sample[15], previous_sample};
  assign diff_mag = diff[16] ? (17'd0 - diff) : diff;

  // next ramp point: q += q0, r += r0, fold remainder once
  assign r_sum  = {1'b0, acc_r} + {1'b0, div_r};
  assign r_wrap = (r_sum >= {1'b0, eff_ratio});
  assign r_new  = r_wrap ? (r_sum[5:0] - eff_ratio) : r_sum[5:0];
  assign q_new  = acc_q + div_q + {15'd0, r_wrap};
  assign interp = diff_neg ?
                  ({previous_sample[15], previous_sample} - {1'b0, q_new}) :
                  ({previous_sample[15], previous_sample} + {1'b0, q_new});

  assign sil_prod = {6'd0, gap_lo} * {16'd0, eff_ratio};

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = gap_ok ? S_GAP : S_PREP;
        end
      end
      S_GAP: begin
        if (out_free) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == 4'd0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && (k == eff_ratio)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      upsample_ratio <= RATIO_RESET;
      max_gap        <= MAX_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPSAMPLE_RATIO: upsample_ratio <= cfg_data[5:0];
        CFG_MAX_GAP:        max_gap <= cfg_data;
        default:            ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_seen     <= 1'b0;
      expected_timestamp <= 32'd0;
      previous_sample    <= 16'sd0;
    end else begin
      if (accept) begin
        if (in_data.first_of_packet) begin
          expected_timestamp <= in_data.packet_timestamp + 32'd1;
          timestamp_seen     <= 1'b1;
        end else begin
          expected_timestamp <= expected_timestamp + 32'd1;
        end
      end
      if ((state == S_GAP) && out_free) begin
        previous_sample <= 16'sd0;
      end else if ((state == S_EMIT) && out_free && (k == eff_ratio)) begin
        previous_sample <= new_sample;
      end
    end
  end

  // datapath work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      new_sample <= mulaw_expand(in_data.code);
      gap_lo     <= gap[15:0];
    end
    case (state)
      S_PREP: begin
        diff_neg <= diff[16];
        div_q    <= diff_mag[15:0];
        div_r    <= 6'd0;
        div_cnt  <= 4'(DivBits - 1);
        acc_q    <= 16'd0;
        acc_r    <= 6'd0;
        k        <= 6'd1;
      end
      S_DIV: begin
        div_q   <= {div_q[DivBits-2:0], div_ge};
        div_r   <= div_ge ? (div_part[5:0] - eff_ratio) : div_part[5:0];
        div_cnt <= div_cnt - 4'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          acc_q <= q_new;
          acc_r <= r_new;
          k     <= k + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_GAP || state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_GAP) begin
        out_data.sample        <= 16'sd0;
        out_data.is_silence    <= 1'b1;
        out_data.silence_count <= sil_prod[20:0];
        out_data.last          <= 1'b0;
      end else if (state == S_EMIT) begin
        out_data.sample        <= interp[15:0];
        out_data.is_silence    <= 1'b0;
        out_data.silence_count <= 21'd0;
        out_data.last          <= (k == eff_ratio);
      end
    end
  end

endmodule

// ===== tb/pcm_stream_checker.sv =====
// Checker: predicts the PCM result stream from observed items and compares it.
module pcm_stream_checker
  import mdug_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int ExpandBias = 'h84;

  // shadow of the block's registers and state
  logic [5:0]         ratio_reg;
  logic [15:0]        gap_limit;
  logic               ts_seen;
  logic [31:0]        next_ts;
  logic signed [15:0] last_pcm;

  out_t pcm_due[$];

  function automatic int expand_mulaw(input logic [7:0] code);
    logic [7:0] flipped;
    int mag;
    flipped = ~code;
    mag = (int'(flipped[3:0]) * 8 + ExpandBias) << flipped[6:4];
    return flipped[7] ? ExpandBias - mag : mag - ExpandBias;
  endfunction

  task automatic predict_pcm(input in_t item);
    int unsigned eff;
    logic [31:0] gap;
    int target;
    int base;
    int v;
    out_t r;
    if (ratio_reg == 6'd0) eff = 1;
    else if (ratio_reg > RATIO_MAX) eff = {26'd0, RATIO_MAX};
    else eff = {26'd0, ratio_reg};
    if (item.first_of_packet) begin
      if (ts_seen) begin
        gap = item.packet_timestamp - next_ts;
        // positive gap within limit: one silence run, ramp restarts from zero
        if (gap != 32'd0 && !gap[31] && gap <= {16'd0, gap_limit}) begin
          r = '0;
          r.is_silence = 1'b1;
          r.silence_count = 21'(gap * eff);
          pcm_due.push_back(r);
          last_pcm = '0;
        end
      end
      next_ts = item.packet_timestamp + 32'd1;
      ts_seen = 1'b1;
    end else begin
      next_ts = next_ts + 32'd1;
    end
    target = expand_mulaw(item.code);
    base = int'(last_pcm);
    for (int k = 1; k <= int'(eff); k++) begin
      r = '0;
      v = base + ((target - base) * k) / int'(eff);
      r.sample = 16'(v);
      r.last = (k == int'(eff));
      pcm_due.push_back(r);
    end
    last_pcm = 16'(target);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      ratio_reg = RATIO_RESET;
      gap_limit = MAX_GAP_RESET;
      ts_seen = 1'b0;
      next_ts = '0;
      last_pcm = '0;
      mismatches = 0;
      pcm_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_UPSAMPLE_RATIO) ratio_reg = cfg_data[5:0];
        else gap_limit = cfg_data;
      end
      if (in_valid && !in_stall) predict_pcm(in_data);
      if (out_valid && !out_stall) begin
        if (pcm_due.size() == 0) begin
          $error("unexpected result: sample %0d is_silence %0b silence_count %0d last %0b",
                 out_data.sample, out_data.is_silence, out_data.silence_count,
                 out_data.last);
          mismatches++;
        end else begin
          want = pcm_due.pop_front();
          if (out_data.sample !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample, out_data.sample);
            mismatches++;
          end
          if (out_data.is_silence !== want.is_silence) begin
            $error("is_silence: expected %0b, actual %0b", want.is_silence,
                   out_data.is_silence);
            mismatches++;
          end
          if (out_data.silence_count !== want.silence_count) begin
            $error("silence_count: expected %0d, actual %0d", want.silence_count,
                   out_data.silence_count);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_data.last);
            mismatches++;
          end
        end
      end
    end
    outstanding = pcm_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top: stimulus, register phases, watchdog and verdict for the core.
module tb;
  import mdug_pkg::*;

  // longest stretch without any handshake or register write before giving up
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          outstanding;

  // stimulus-side mirror of the timestamp the block expects next
  logic [31:0] ts_cursor;
  logic [15:0] cur_max_gap;
  bit          in_burst;

  // output-side stall bookkeeping
  int          taken_cnt = 0;
  int          taken_seen = 0;
  int          hold_left = 0;
  bit          out_burst = 1'b0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  mulaw_decode_upsample_gapfill_core u_dut (.*);

  pcm_stream_checker u_pcm_check (.*);

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (out_valid && !out_stall) taken_cnt++;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("mulaw_decode_upsample_gapfill_core verification failed");
      $finish;
    end
  end

  // Receiver: after each taken result, hold stall for a randomly drawn length.
  // The countdown runs whether or not a result is waiting, so stalls land on
  // every phase of the divider and emit sequence. Burst mode never stalls.
  always @(negedge clk) begin
    if (taken_cnt != taken_seen) begin
      taken_seen = taken_cnt;
      if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
      hold_left = out_burst ? 0 : $urandom_range(0, 15);
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no re-raise.
  task automatic push_byte(input in_t item);
    int wait_cycles;
    wait_cycles = in_burst ? 0 : $urandom_range(0, 15);
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] code, input logic first,
                           input logic [31:0] ts);
    in_t item;
    item.code = code;
    item.first_of_packet = first;
    item.packet_timestamp = ts;
    ts_cursor = first ? ts + 32'd1 : ts_cursor + 32'd1;
    push_byte(item);
  endtask

  // Registers change only with the pipeline empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic [5:0] ratio, input logic [15:0] gap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UPSAMPLE_RATIO;
    cfg_data <= {10'd0, ratio};
    @(negedge clk);
    cfg_index <= CFG_MAX_GAP;
    cfg_data <= gap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_max_gap = gap;
  endtask

  // Timestamp step for a new packet: mostly contiguous or fillable gaps,
  // plus limit edges, backward jumps and wild values.
  function automatic logic [31:0] pick_gap();
    logic [31:0] lim;
    lim = (cur_max_gap == 16'd0) ? 32'd1
        : (cur_max_gap > 16'd50) ? 32'd50 : {16'd0, cur_max_gap};
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      3, 4, 5: return $urandom_range(1, lim);
      6:       return {16'd0, cur_max_gap};
      7:       return {16'd0, cur_max_gap} + 32'd1;
      8:       return -$urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed packets with random content; the rest are stray
  // continuation bytes carrying junk timestamps.
  task automatic random_packets(input int n_bytes);
    int left;
    int plen;
    left = n_bytes;
    while (left > 0) begin
      in_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 8) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom);
        left--;
      end else begin
        plen = $urandom_range(1, 6);
        send_byte(8'($urandom_range(0, 255)), 1'b1, ts_cursor + pick_gap());
        left--;
        for (int i = 1; i < plen && left > 0; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom);
          left--;
        end
      end
    end
  endtask

  function automatic logic [5:0] pick_ratio();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return RATIO_MAX;
      default: return 6'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [15:0] pick_max_gap();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_UPSAMPLE_RATIO;
    cfg_data = '0;
    ts_cursor = '0;
    cur_max_gap = MAX_GAP_RESET;
    in_burst = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed, reset registers: ratio 6, max gap 24000 ---
    // bytes before any packet start decode, move the expected timestamp, fill no gap
    send_byte(8'h00, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0, 32'h0000_0000);
    // first packet start: nothing seen yet, so no fill
    send_byte(8'h80, 1'b1, 32'd100);
    // timestamp on a continuation byte is ignored
    send_byte(8'h7F, 1'b0, 32'hDEAD_BEEF);
    send_byte(8'h00, 1'b1, ts_cursor);                    // contiguous
    send_byte(8'hFF, 1'b1, ts_cursor + 32'd7);            // short fill
    send_byte(8'h7F, 1'b1, ts_cursor - 32'd5);            // backward jump
    send_byte(8'h01, 1'b1, ts_cursor + 32'd24000);        // gap at limit
    send_byte(8'hFE, 1'b1, ts_cursor + 32'd24001);        // one past limit
    send_byte(8'h55, 1'b1, ts_cursor + 32'h8000_0000);    // reads as negative
    send_byte(8'hAA, 1'b1, ts_cursor + 32'h7FFF_FFFF);    // largest positive

    // largest ratio and gap: biggest silence run, then full-scale swings
    drain_results();
    set_regs(RATIO_MAX, 16'hFFFF);
    send_byte(8'h80, 1'b1, ts_cursor + 32'd65535);
    send_byte(8'h00, 1'b0, 32'd0);
    send_byte(8'h80, 1'b0, 32'd0);

    // ratio zero behaves as one; zero max gap never fills
    drain_results();
    set_regs(6'd0, 16'd0);
    send_byte(8'h00, 1'b1, ts_cursor + 32'd1);
    send_byte(8'h80, 1'b0, 32'd0);

    // ratio above range is capped; max gap of one
    drain_results();
    set_regs(6'd63, 16'd1);
    send_byte(8'h3C, 1'b1, ts_cursor + 32'd1);
    send_byte(8'hC3, 1'b1, ts_cursor + 32'd2);

    drain_results();
    set_regs(6'd33, 16'hFFFF);
    send_byte(8'h0F, 1'b1, ts_cursor + 32'd3);
    send_byte(8'hF0, 1'b1, ts_cursor + 32'd65536);

    // --- random phases; first one pins the smallest ratio ---
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      if (ph == 0) set_regs(RATIO_MIN, 16'hFFFF);
      else set_regs(pick_ratio(), pick_max_gap());
      random_packets(30);
    end

    drain_results();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mulaw_decode_upsample_gapfill_core verification clean");
    end else begin
      $display("mulaw_decode_upsample_gapfill_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mdug_pkg.sv
hw/rtl/mulaw_decode_upsample_gapfill_core.sv
tb/pcm_stream_checker.sv
tb/tb.sv
